FILE: rtl/pdfa_pkg.sv
package pdfa_pkg;

  localparam int MAX_STATES  = 16;
  localparam int MAX_LETTERS = 16;
  localparam int PROB_BITS   = 16;

  localparam int STATE_W = $clog2(MAX_STATES);
  localparam int LETTER_W = $clog2(MAX_LETTERS);
  localparam int ADDR_W = STATE_W + LETTER_W;
  localparam int DEPTH = MAX_STATES * MAX_LETTERS;
  localparam int CNT_W = 5;
  localparam int TGT_W = 6;
  localparam int ENTRY_W = TGT_W + PROB_BITS;
  localparam int REM_W = PROB_BITS + 2;

  localparam logic [CNT_W-1:0] STATES_RESET  = CNT_W'(MAX_STATES);
  localparam logic [CNT_W-1:0] LETTERS_RESET = CNT_W'(MAX_LETTERS);

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_ACCEPT = 2'd1,
    MODE_GEN    = 2'd2
  } mode_t;

  typedef enum logic {
    REG_NUM_STATES  = 1'b0,
    REG_NUM_LETTERS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [3:0]              row_state;
    logic [3:0]              letter;
    logic signed [TGT_W-1:0] next_state;
    logic [PROB_BITS-1:0]    probability;
    logic                    is_last;
    logic [PROB_BITS-1:0]    draw;
  } item_t;

  typedef struct packed {
    logic [3:0] out_letter;
    logic       emitted;
    logic       string_done;
    logic       verdict;
    logic       verdict_valid;
  } res_t;

  typedef struct packed {
    logic load;
    logic start;
    logic acc_eval;
    logic gen_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       gen_stop;
    logic       out_free;
  } stat_t;

  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

FILE: rtl/pdfa_ifs.sv
interface pdfa_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic [3:0]                          row_state;
  logic [3:0]                          letter;
  logic signed [pdfa_pkg::TGT_W-1:0]   next_state;
  logic [pdfa_pkg::PROB_BITS-1:0]      probability;
  logic                                is_last;
  logic [pdfa_pkg::PROB_BITS-1:0]      draw;

  modport source (output valid, mode, row_state, letter, next_state, probability,
                  is_last, draw, input ready);
  modport sink (input valid, mode, row_state, letter, next_state, probability,
                is_last, draw, output ready);
endinterface

interface pdfa_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_letter;
  logic       emitted;
  logic       string_done;
  logic       verdict;
  logic       verdict_valid;

  modport source (output valid, out_letter, emitted, string_done, verdict,
                  verdict_valid, input ready);
  modport sink (input valid, out_letter, emitted, string_done, verdict,
                verdict_valid, output ready);
endinterface

FILE: rtl/pdfa_ctrl.sv
module pdfa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pdfa_pkg::stat_t stat,
  output pdfa_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_ACC,
    S_GEN,
    S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_START;
        end
        S_START: begin
          if (stat.mode == pdfa_pkg::MODE_ACCEPT) state <= S_ACC;
          else if (stat.mode == pdfa_pkg::MODE_GEN) state <= S_GEN;
          else state <= S_DONE;
        end
        S_ACC: begin
          state <= S_DONE;
        end
        S_GEN: begin
          if (stat.gen_stop) state <= S_DONE;
        end
        S_DONE: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.start    = (state == S_START);
    cmd.acc_eval = (state == S_ACC);
    cmd.gen_step = (state == S_GEN);
    cmd.out_load = (state == S_DONE) && stat.out_free;
  end

endmodule

FILE: rtl/pdfa_dp.sv
module pdfa_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pdfa_pkg::CNT_W-1:0]  n_eff,
  input  logic [pdfa_pkg::CNT_W-1:0]  l_eff,
  input  pdfa_pkg::item_t             item_in,
  input  pdfa_pkg::cmd_t              cmd,
  output pdfa_pkg::stat_t             stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pdfa_pkg::res_t              out_res
);

  pdfa_pkg::item_t it;
  pdfa_pkg::res_t  res;

  logic [pdfa_pkg::ENTRY_W-1:0] mem [pdfa_pkg::DEPTH];
  logic [pdfa_pkg::DEPTH-1:0]   ent_vld;
  logic [pdfa_pkg::ENTRY_W-1:0] rd_data;
  logic                         rd_vld;
  logic [pdfa_pkg::ADDR_W-1:0]  rd_addr;
  logic [pdfa_pkg::ADDR_W-1:0]  wr_addr;
  logic                         wr_en;

  logic [pdfa_pkg::CNT_W-1:0]    check_cursor;
  logic                          check_dead;
  logic [pdfa_pkg::CNT_W-1:0]    sample_cursor;
  logic [pdfa_pkg::STATE_W-1:0]  gen_row;
  logic [pdfa_pkg::LETTER_W-1:0] k_eval;
  logic signed [pdfa_pkg::REM_W-1:0] rem;

  logic signed [pdfa_pkg::TGT_W-1:0] tgt;
  logic [pdfa_pkg::PROB_BITS-1:0]    prob;
  logic                              tgt_ok;
  logic [pdfa_pkg::CNT_W-1:0]        cur_g;
  logic                              acc_dead;
  logic [pdfa_pkg::CNT_W-1:0]        acc_cur;
  logic signed [pdfa_pkg::REM_W-1:0] rem_sub;
  logic                              gen_use;
  logic                              gen_hit;
  logic                              out_free;

  assign tgt    = rd_data[pdfa_pkg::ENTRY_W-1:pdfa_pkg::PROB_BITS];
  assign prob   = rd_data[pdfa_pkg::PROB_BITS-1:0];
  assign tgt_ok = rd_vld && !tgt[pdfa_pkg::TGT_W-1]
                  && (tgt[pdfa_pkg::CNT_W-1:0] <= n_eff);
  assign cur_g  = (sample_cursor >= n_eff) ? '0 : sample_cursor;

  assign wr_en   = cmd.start && (it.mode == pdfa_pkg::MODE_WRITE);
  assign wr_addr = {it.row_state, it.letter};

  always_comb begin
    if (cmd.start && (it.mode == pdfa_pkg::MODE_ACCEPT)) begin
      rd_addr = {check_cursor[pdfa_pkg::STATE_W-1:0], it.letter};
    end else if (cmd.start) begin
      rd_addr = {cur_g[pdfa_pkg::STATE_W-1:0], {pdfa_pkg::LETTER_W{1'b0}}};
    end else begin
      rd_addr = {gen_row, k_eval + pdfa_pkg::LETTER_W'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {it.next_state, it.probability};
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) ent_vld[wr_addr] <= 1'b1;
      rd_vld <= ent_vld[rd_addr];
    end
  end

  always_comb begin
    acc_dead = check_dead;
    acc_cur  = check_cursor;
    if (check_cursor >= n_eff) begin
      acc_dead = 1'b1;
    end else if (!check_dead) begin
      if (tgt_ok && ({1'b0, it.letter} < l_eff)) acc_cur = tgt[pdfa_pkg::CNT_W-1:0];
      else acc_dead = 1'b1;
    end
  end

  assign rem_sub = rem - $signed({2'b00, prob});
  assign gen_use = tgt_ok && ({1'b0, k_eval} < l_eff);
  assign gen_hit = gen_use && (rem_sub[pdfa_pkg::REM_W-1] || (rem_sub == '0));

  assign out_free      = !out_valid || out_ready;
  assign stat.mode     = it.mode;
  assign stat.out_free = out_free;
  assign stat.gen_stop = gen_hit || ({1'b0, k_eval} == (l_eff - pdfa_pkg::CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (cmd.load) it <= item_in;
    if (cmd.start) begin
      res     <= '0;
      gen_row <= cur_g[pdfa_pkg::STATE_W-1:0];
      k_eval  <= '0;
      rem     <= $signed({2'b00, it.draw});
    end
    if (cmd.gen_step) begin
      k_eval <= k_eval + pdfa_pkg::LETTER_W'(1);
      if (gen_use) rem <= rem_sub;
      if (gen_hit) begin
        res.out_letter  <= k_eval;
        res.emitted     <= 1'b1;
        res.string_done <= (tgt[pdfa_pkg::CNT_W-1:0] == n_eff);
      end
    end
    if (cmd.acc_eval && it.is_last) begin
      res.verdict       <= !acc_dead && (acc_cur == n_eff);
      res.verdict_valid <= 1'b1;
    end
    if (cmd.out_load) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_cursor  <= '0;
      check_dead    <= 1'b0;
      sample_cursor <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.start && (it.mode == pdfa_pkg::MODE_GEN)) sample_cursor <= cur_g;
      if (cmd.gen_step && gen_hit) begin
        if (tgt[pdfa_pkg::CNT_W-1:0] == n_eff) sample_cursor <= '0;
        else sample_cursor <= tgt[pdfa_pkg::CNT_W-1:0];
      end
      if (cmd.acc_eval) begin
        if (it.is_last) begin
          check_cursor <= '0;
          check_dead   <= 1'b0;
        end else begin
          check_cursor <= acc_cur;
          check_dead   <= acc_dead;
        end
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/pdfa_accept_and_sample.sv
// channel  dir  handshake      payload
// item     in   valid/ready    mode, row_state, letter, next_state, probability,
//                              is_last, draw
// result   out  valid/ready    out_letter, emitted, string_done, verdict,
//                              verdict_valid
// apb      in   psel/penable   num_states at 0x0, num_letters at 0x4
//
// Write item: one table write. Accept item: one registered table read.
// Generate item: the row walk reads one entry per cycle through the single table
// read port, stopping at the chosen letter or at the last letter in use.
// Reset marks every table entry empty at once and clears the cursors.
// A new item is taken while the previous result waits in the output register.
module pdfa_accept_and_sample (
  input  logic               clk,
  input  logic               rst,
  pdfa_in_if.sink            item,
  pdfa_out_if.source         result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [pdfa_pkg::CNT_W-1:0] num_states;
  logic [pdfa_pkg::CNT_W-1:0] num_letters;
  logic [pdfa_pkg::CNT_W-1:0] n_eff;
  logic [pdfa_pkg::CNT_W-1:0] l_eff;
  pdfa_pkg::reg_idx_t         reg_sel;
  pdfa_pkg::item_t            item_in;
  pdfa_pkg::res_t             out_res;
  pdfa_pkg::cmd_t             cmd;
  pdfa_pkg::stat_t            stat;
  logic                       out_valid;

  assign pready  = 1'b1;
  assign reg_sel = pdfa_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states  <= pdfa_pkg::STATES_RESET;
      num_letters <= pdfa_pkg::LETTERS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        pdfa_pkg::REG_NUM_STATES:  num_states  <= pwdata[pdfa_pkg::CNT_W-1:0];
        pdfa_pkg::REG_NUM_LETTERS: num_letters <= pwdata[pdfa_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      pdfa_pkg::REG_NUM_STATES:  prdata = {{(32 - pdfa_pkg::CNT_W){1'b0}}, num_states};
      pdfa_pkg::REG_NUM_LETTERS: prdata = {{(32 - pdfa_pkg::CNT_W){1'b0}}, num_letters};
      default:                   prdata = '0;
    endcase
  end

  assign n_eff = pdfa_pkg::sat_count(num_states, pdfa_pkg::CNT_W'(pdfa_pkg::MAX_STATES));
  assign l_eff = pdfa_pkg::sat_count(num_letters, pdfa_pkg::CNT_W'(pdfa_pkg::MAX_LETTERS));

  assign item_in.mode        = item.mode;
  assign item_in.row_state   = item.row_state;
  assign item_in.letter      = item.letter;
  assign item_in.next_state  = item.next_state;
  assign item_in.probability = item.probability;
  assign item_in.is_last     = item.is_last;
  assign item_in.draw        = item.draw;

  pdfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdfa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .n_eff     (n_eff),
    .l_eff     (l_eff),
    .item_in   (item_in),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .out_res   (out_res)
  );

  assign result.valid         = out_valid;
  assign result.out_letter    = out_res.out_letter;
  assign result.emitted       = out_res.emitted;
  assign result.string_done   = out_res.string_done;
  assign result.verdict       = out_res.verdict;
  assign result.verdict_valid = out_res.verdict_valid;

endmodule

FILE: sim/tb_pdfa_accept_and_sample.sv
`timescale 1ns / 100ps

module tb_pdfa_accept_and_sample;
  import pdfa_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam res_t QUIET = 8'h00;
  localparam res_t REJECT = 8'h01;
  localparam res_t ACCEPT = 8'h03;
  localparam int ITEM_GOAL = 850;
  localparam int NUM_PHASES = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_BITS = $bits(item_t);

  typedef struct packed {
    logic [1:0]        op;
    logic [3:0]        row;
    logic [3:0]        letter;
    logic signed [5:0] target;
    logic [15:0]       prob;
    logic              last;
    logic [15:0]       draw;
    logic              typed;
    res_t              want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [26] = '{
    '{MODE_ACCEPT, 4'd0,  4'd0,  6'sd0,  16'h0000, 1'b1, 16'h0000, 1'b1, REJECT},
    '{MODE_GEN,    4'd0,  4'd0,  6'sd0,  16'h0000, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_UNUSED, 4'd15, 4'd15, -6'sd1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, QUIET},
    '{MODE_WRITE,  4'd0,  4'd0,  6'sd1,  16'h8000, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_WRITE,  4'd1,  4'd15, 6'sd16, 16'hFFFF, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_WRITE,  4'd0,  4'd15, -6'sd1, 16'hFFFF, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_WRITE,  4'd0,  4'd3,  6'sd16, 16'h8000, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_WRITE,  4'd1,  4'd2,  6'sd31, 16'h1000, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_WRITE,  4'd1,  4'd1,  6'h20,  16'h0000, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_ACCEPT, 4'd0,  4'd0,  6'sd0,  16'h0000, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_ACCEPT, 4'd0,  4'd15, 6'sd0,  16'h0000, 1'b1, 16'h0000, 1'b1, ACCEPT},
    '{MODE_ACCEPT, 4'd0,  4'd3,  6'sd0,  16'h0000, 1'b1, 16'h0000, 1'b1, ACCEPT},
    '{MODE_ACCEPT, 4'd0,  4'd3,  6'sd0,  16'h0000, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_ACCEPT, 4'd0,  4'd0,  6'sd0,  16'h0000, 1'b1, 16'h0000, 1'b1, REJECT},
    '{MODE_ACCEPT, 4'd0,  4'd0,  6'sd0,  16'h0000, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_ACCEPT, 4'd0,  4'd2,  6'sd0,  16'h0000, 1'b1, 16'h0000, 1'b1, REJECT},
    '{MODE_ACCEPT, 4'd0,  4'd15, 6'sd0,  16'h0000, 1'b1, 16'h0000, 1'b1, REJECT},
    '{MODE_GEN,    4'd0,  4'd0,  6'sd0,  16'h0000, 1'b0, 16'h0000, 1'b0, QUIET},
    '{MODE_GEN,    4'd0,  4'd0,  6'sd0,  16'h0000, 1'b0, 16'hFFFF, 1'b0, QUIET},
    '{MODE_GEN,    4'd0,  4'd0,  6'sd0,  16'h0000, 1'b0, 16'hFFFF, 1'b0, QUIET},
    '{MODE_WRITE,  4'd0,  4'd0,  6'sd1,  16'h0001, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_WRITE,  4'd0,  4'd3,  6'sd16, 16'h0001, 1'b0, 16'h0000, 1'b1, QUIET},
    '{MODE_GEN,    4'd0,  4'd0,  6'sd0,  16'h0000, 1'b0, 16'h0003, 1'b0, QUIET},
    '{MODE_GEN,    4'd0,  4'd0,  6'sd0,  16'h0000, 1'b0, 16'h0002, 1'b0, QUIET},
    '{MODE_GEN,    4'd0,  4'd0,  6'sd0,  16'h0000, 1'b0, 16'h0001, 1'b0, QUIET},
    '{MODE_ACCEPT, 4'd0,  4'd0,  6'sd0,  16'h0000, 1'b0, 16'h0000, 1'b1, QUIET}
  };

  localparam logic [4:0] PHASE_STATES [NUM_PHASES] =
    '{5'd0, 5'd3, 5'd4, 5'd31, 5'd16, 5'd8, 5'd2, 5'd12};
  localparam logic [4:0] PHASE_LETTERS [NUM_PHASES] =
    '{5'd31, 5'd1, 5'd4, 5'd0, 5'd16, 5'd3, 5'd16, 5'd9};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  pdfa_in_if item_ch ();
  pdfa_out_if result_ch ();

  pdfa_accept_and_sample DUT (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  int tgt_tab [DEPTH];
  logic [PROB_BITS-1:0] prob_tab [DEPTH];
  int chk_cursor, sample_at;
  bit chk_dead;
  logic [4:0] states_reg, letters_reg;
  res_t pending_results [$];

  int fail_count = 0;
  int items_sent = 0;
  int src_idle = 36;
  int snk_idle = 67;
  int stall_cycles = 0;
  int n_verdicts = 0, n_accepted = 0, n_emitted = 0, n_done = 0, n_silent = 0;

  function automatic int clamp_count(logic [4:0] v, int hi);
    if (v == 5'd0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int usable_target(int s, int k);
    int n, t;
    n = clamp_count(states_reg, MAX_STATES);
    if (s < 0 || s >= n || k >= clamp_count(letters_reg, MAX_LETTERS)) return -1;
    t = tgt_tab[s * MAX_LETTERS + k];
    if (t < 0 || t > n) return -1;
    return t;
  endfunction

  function automatic int sample_row();
    return (sample_at >= clamp_count(states_reg, MAX_STATES)) ? 0 : sample_at;
  endfunction

  function automatic res_t automaton_step(item_t it);
    res_t r;
    int n, t, cur;
    longint rem;
    r = QUIET;
    n = clamp_count(states_reg, MAX_STATES);
    case (it.mode)
      MODE_WRITE: begin
        tgt_tab[{it.row_state, it.letter}] = int'($signed(it.next_state));
        prob_tab[{it.row_state, it.letter}] = it.probability;
      end
      MODE_ACCEPT: begin
        if (chk_cursor >= n) begin
          chk_dead = 1'b1;
        end else if (!chk_dead) begin
          t = usable_target(chk_cursor, int'(it.letter));
          if (t < 0) chk_dead = 1'b1;
          else chk_cursor = t;
        end
        if (it.is_last) begin
          r.verdict = !chk_dead && chk_cursor == n;
          r.verdict_valid = 1'b1;
          chk_cursor = 0;
          chk_dead = 1'b0;
        end
      end
      MODE_GEN: begin
        cur = sample_row();
        sample_at = cur;
        rem = longint'(it.draw);
        for (int k = 0; k < MAX_LETTERS; k++) begin
          t = usable_target(cur, k);
          if (t >= 0 && !r.emitted) begin
            rem -= longint'(prob_tab[cur * MAX_LETTERS + k]);
            if (rem <= 0) begin
              r.out_letter = 4'(k);
              r.emitted = 1'b1;
              r.string_done = (t == n);
              sample_at = (t == n) ? 0 : t;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t random_item(logic [1:0] mode);
    item_t it;
    it = ITEM_BITS'({$urandom, $urandom});
    it.mode = mode;
    return it;
  endfunction

  task automatic send_item(item_t it, bit typed, res_t typed_want);
    res_t want;
    while ($urandom_range(99) < src_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.mode <= it.mode;
    item_ch.row_state <= it.row_state;
    item_ch.letter <= it.letter;
    item_ch.next_state <= it.next_state;
    item_ch.probability <= it.probability;
    item_ch.is_last <= it.is_last;
    item_ch.draw <= it.draw;
    do @(posedge clk); while (!item_ch.ready);
    want = automaton_step(it);
    if (it.mode == MODE_GEN && !want.emitted) n_silent++;
    pending_results.push_back(typed ? typed_want : want);
    items_sent++;
    if (items_sent < ITEM_GOAL / 3) begin
      src_idle = 36;
      snk_idle = 67;
    end else if (items_sent < 2 * ITEM_GOAL / 3) begin
      src_idle = 67;
      snk_idle = 36;
    end else begin
      src_idle = 0;
      snk_idle = 0;
    end
  endtask

  // hold the item channel until every pending transfer has come back
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [4:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == REG_NUM_STATES) states_reg = value;
    else letters_reg = value;
  endtask

  // walk the table from the current check cursor, mostly along live edges
  task automatic send_string();
    item_t it;
    int cur, len, nxt, n;
    int picks [$];
    bit broken;
    n = clamp_count(states_reg, MAX_STATES);
    cur = chk_dead ? -1 : chk_cursor;
    len = $urandom_range(1, 8);
    broken = ($urandom_range(9) == 0);
    for (int i = 0; i < len; i++) begin
      picks.delete();
      for (int k = 0; k < MAX_LETTERS; k++)
        if (usable_target(cur, k) >= 0) picks.push_back(k);
      it = random_item(MODE_ACCEPT);
      if (picks.size() > 0 && !(broken && $urandom_range(2) == 0))
        it.letter = 4'(picks[$urandom_range(picks.size() - 1)]);
      nxt = usable_target(cur, int'(it.letter));
      it.is_last = (i == len - 1) || (nxt == n && !broken && $urandom_range(3) != 0);
      cur = nxt;
      send_item(it, 1'b0, QUIET);
      if (it.is_last) break;
    end
  endtask

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst) result_ch.ready <= 1'b0;
    else result_ch.ready <= ($urandom_range(99) >= snk_idle);
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_letter", want.out_letter, result_ch.out_letter);
        check_field("emitted", 4'(want.emitted), 4'(result_ch.emitted));
        check_field("string_done", 4'(want.string_done), 4'(result_ch.string_done));
        check_field("verdict", 4'(want.verdict), 4'(result_ch.verdict));
        check_field("verdict_valid", 4'(want.verdict_valid), 4'(result_ch.verdict_valid));
        n_verdicts += int'(want.verdict_valid);
        n_accepted += int'(want.verdict);
        n_emitted += int'(want.emitted);
        n_done += int'(want.string_done);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** pdfa_accept_and_sample: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    item_t it;
    dir_row_t d;
    int n, l, cur, total, phase_end, mid;
    bit paused;
    item_ch.valid = 1'b0;
    item_ch.mode = MODE_WRITE;
    item_ch.row_state = '0;
    item_ch.letter = '0;
    item_ch.next_state = '0;
    item_ch.probability = '0;
    item_ch.is_last = 1'b0;
    item_ch.draw = '0;
    result_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tgt_tab[i] = -1;
      prob_tab[i] = '0;
    end
    chk_cursor = 0;
    chk_dead = 1'b0;
    sample_at = 0;
    states_reg = STATES_RESET;
    letters_reg = LETTERS_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      d = DIRECTED[i];
      it = '0;
      it.mode = d.op;
      it.row_state = d.row;
      it.letter = d.letter;
      it.next_state = d.target;
      it.probability = d.prob;
      it.is_last = d.last;
      it.draw = d.draw;
      send_item(it, d.typed, d.want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apb_write(REG_NUM_STATES, PHASE_STATES[p]);
      apb_write(REG_NUM_LETTERS, PHASE_LETTERS[p]);
      n = clamp_count(states_reg, MAX_STATES);
      l = clamp_count(letters_reg, MAX_LETTERS);

      for (int s = 0; s < n; s++) begin
        repeat (2) begin
          it = random_item(MODE_WRITE);
          it.row_state = 4'(s);
          if ($urandom_range(9) != 0) it.letter = 4'($urandom_range(l - 1));
          case ($urandom_range(9))
            0: ;
            1, 2, 3: it.next_state = 6'(n);
            default: it.next_state = 6'($urandom_range(n));
          endcase
          send_item(it, 1'b0, QUIET);
        end
      end

      phase_end = $size(DIRECTED) + (p + 1) * (ITEM_GOAL - $size(DIRECTED)) / NUM_PHASES;
      mid = items_sent + (phase_end - items_sent) / 2;
      paused = 1'b0;
      while (items_sent < phase_end) begin
        if (!paused && items_sent >= mid) begin
          drain();
          paused = 1'b1;
        end
        case ($urandom_range(99)) inside
          [0:7]: send_item(random_item(MODE_WRITE), 1'b0, QUIET);
          [8:11]: send_item(random_item(MODE_UNUSED), 1'b0, QUIET);
          [12:49]: send_string();
          [50:55]: send_item(random_item(MODE_ACCEPT), 1'b0, QUIET);
          default: begin
            it = random_item(MODE_GEN);
            cur = sample_row();
            total = 0;
            for (int k = 0; k < MAX_LETTERS; k++)
              if (usable_target(cur, k) >= 0) total += int'(prob_tab[cur * MAX_LETTERS + k]);
            if (total > 65535) total = 65535;
            case ($urandom_range(9))
              0: it.draw = 16'(total);
              1, 2, 3, 4, 5: it.draw = 16'($urandom_range(total));
              default: ;
            endcase
            send_item(it, 1'b0, QUIET);
          end
        endcase
      end
    end

    drain();
    repeat (25) @(posedge clk);

    $display("Ran %0d items over %0d register settings with both sides stalling.",
             items_sent, NUM_PHASES + 1);
    $display("Saw %0d verdicts (%0d accepted), %0d letters sampled, %0d strings done, %0d empty draws.",
             n_verdicts, n_accepted, n_emitted, n_done, n_silent);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("** pdfa_accept_and_sample: PASSED **");
    end else begin
      $display("** pdfa_accept_and_sample: FAILED **");
    end
    $finish;
  end

endmodule
